FILE: src/amfe_pkg.sv
// ----------------------------------------------------------------------------
// amfe_pkg
// Shared types and constants of the Euler-angle affine map builder.
// ----------------------------------------------------------------------------
package amfe_pkg;

	// field types
	typedef logic signed [19:0] ctr_t;    // Q12.8 coordinate
	typedef logic signed [15:0] ang_t;    // Q3.13 radians
	typedef logic [15:0]        scl_t;    // Q4.12 unsigned
	typedef logic signed [17:0] sc_t;     // Q16 sine or cosine
	typedef logic signed [18:0] rot_t;    // Q16 rotation entry
	typedef logic [31:0]        ratio_t;  // Q16 unsigned size ratio
	typedef logic signed [22:0] vec_t;    // Q15.8 origin shift
	typedef logic signed [31:0] coef_t;   // Q16.16 result

	// APB address width: seven 32-bit registers
	localparam int PADDR_W = 5;

	// number of the row that ends a run
	localparam logic [1:0] ROW_LAST = 2'd2;

	// per-item side data carried along the pipeline
	typedef struct packed {
		ctr_t cx;
		ctr_t cy;
		ctr_t cz;
		scl_t kx;
		scl_t ky;
		scl_t kz;
	} side_t;

	// values derived from the configuration registers
	typedef struct packed {
		ratio_t ratio_xy;
		ratio_t ratio_z;
		vec_t   v0;
		vec_t   v1;
		vec_t   v2;
	} cal_t;

endpackage

FILE: src/amfe_if.sv
// ----------------------------------------------------------------------------
// amfe_in_if / amfe_out_if
// Valid/ready channels for input items and result rows.
// ----------------------------------------------------------------------------
interface amfe_in_if;
	logic            valid;
	logic            ready;
	amfe_pkg::ctr_t  center_x;
	amfe_pkg::ctr_t  center_y;
	amfe_pkg::ctr_t  center_z;
	amfe_pkg::ang_t  angle_x;
	amfe_pkg::ang_t  angle_y;
	amfe_pkg::ang_t  angle_z;
	amfe_pkg::scl_t  scale_x;
	amfe_pkg::scl_t  scale_y;
	amfe_pkg::scl_t  scale_z;

	modport source (output valid, center_x, center_y, center_z, angle_x, angle_y,
		angle_z, scale_x, scale_y, scale_z, input ready);
	modport sink (input valid, center_x, center_y, center_z, angle_x, angle_y,
		angle_z, scale_x, scale_y, scale_z, output ready);
endinterface

interface amfe_out_if;
	logic            valid;
	logic            ready;
	logic [1:0]      row_index;
	amfe_pkg::coef_t coef_first;
	amfe_pkg::coef_t coef_second;
	amfe_pkg::coef_t coef_third;
	amfe_pkg::coef_t offset_term;
	logic            last_row;

	modport source (output valid, row_index, coef_first, coef_second, coef_third,
		offset_term, last_row, input ready);
	modport sink (input valid, row_index, coef_first, coef_second, coef_third,
		offset_term, last_row, output ready);
endinterface

FILE: src/amfe_cfg.sv
// ----------------------------------------------------------------------------
// amfe_cfg
// APB register file plus a serial divider that derives the size ratios and
// the anterior shift whenever a register changes.
// ----------------------------------------------------------------------------
module amfe_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [amfe_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output amfe_pkg::cal_t                cal,
	output logic                          busy
);

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_AP       = 3'd3;
	localparam logic [2:0] REG_AS       = 3'd4;
	localparam logic [2:0] REG_PP       = 3'd5;
	localparam logic [2:0] REG_PS       = 3'd6;

	localparam logic       ST_IDLE = 1'b0;
	localparam logic       ST_RUN  = 1'b1;

	localparam logic [1:0] PH_RATIO_XY = 2'd0;
	localparam logic [1:0] PH_RATIO_Z  = 2'd1;
	localparam logic [1:0] PH_SHIFT    = 2'd2;

	localparam logic [31:0] SHIFT_Q20 = 32'd1887437;  // 1.8 cm in Q20
	localparam logic [4:0]  LAST_BIT  = 5'd31;

	logic [19:0] x0_q, y0_q, z0_q;
	logic [15:0] ap_q, as_q, pp_q, ps_q;
	logic        dirty_q;
	logic        state_q;
	logic [1:0]  phase_q;
	logic [4:0]  cnt_q;
	logic [31:0] num_q, quo_q;
	logic [15:0] rem_q, den_q;
	logic [31:0] ratio_xy_q, ratio_z_q;
	logic [20:0] d_q;

	logic [2:0]  idx;
	logic        wr;
	logic [15:0] ap_e, pp_e, ps_e;
	logic [1:0]  sel_ph;
	logic [31:0] op_num;
	logic [15:0] op_den;
	logic [16:0] rem_full;
	logic [17:0] diff;
	logic        qbit;
	logic [15:0] rem_nx;
	logic [31:0] quo_nx;

	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;

	// read mux
	always_comb begin
		unique case (idx)
			REG_ORIGIN_X: prdata = {12'd0, x0_q};
			REG_ORIGIN_Y: prdata = {12'd0, y0_q};
			REG_ORIGIN_Z: prdata = {12'd0, z0_q};
			REG_AP:       prdata = {16'd0, ap_q};
			REG_AS:       prdata = {16'd0, as_q};
			REG_PP:       prdata = {16'd0, pp_q};
			REG_PS:       prdata = {16'd0, ps_q};
			default:      prdata = 32'd0;
		endcase
	end

	// register writes; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q <= 20'd0;
			y0_q <= 20'd0;
			z0_q <= 20'd0;
			ap_q <= 16'd4096;
			as_q <= 16'd4096;
			pp_q <= 16'd4096;
			ps_q <= 16'd4096;
		end else if (wr) begin
			unique case (idx)
				REG_ORIGIN_X: x0_q <= pwdata[19:0];
				REG_ORIGIN_Y: y0_q <= pwdata[19:0];
				REG_ORIGIN_Z: z0_q <= pwdata[19:0];
				REG_AP:       ap_q <= pwdata[15:0];
				REG_AS:       as_q <= pwdata[15:0];
				REG_PP:       pp_q <= pwdata[15:0];
				REG_PS:       ps_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// a zero divisor counts as one
	assign ap_e = (ap_q == 16'd0) ? 16'd1 : ap_q;
	assign pp_e = (pp_q == 16'd0) ? 16'd1 : pp_q;
	assign ps_e = (ps_q == 16'd0) ? 16'd1 : ps_q;

	// operands of the division about to start
	assign sel_ph = (state_q == ST_IDLE) ? PH_RATIO_XY : phase_q + 2'd1;

	always_comb begin
		unique case (sel_ph)
			PH_RATIO_XY: begin
				op_num = {ap_q, 16'd0} + {17'd0, pp_e[15:1]};
				op_den = pp_e;
			end
			PH_RATIO_Z: begin
				op_num = {as_q, 16'd0} + {17'd0, ps_e[15:1]};
				op_den = ps_e;
			end
			PH_SHIFT: begin
				op_num = SHIFT_Q20 + {17'd0, ap_e[15:1]};
				op_den = ap_e;
			end
			default: begin
				op_num = 32'd0;
				op_den = 16'd1;
			end
		endcase
	end

	// one restoring step per cycle
	assign rem_full = {rem_q, num_q[31]};
	assign diff     = {1'b0, rem_full} - {2'b00, den_q};
	assign qbit     = !diff[17];
	assign rem_nx   = qbit ? diff[15:0] : rem_full[15:0];
	assign quo_nx   = {quo_q[30:0], qbit};

	// divider sequencer: three divisions after reset and after each write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b1;
			state_q <= ST_IDLE;
			phase_q <= PH_RATIO_XY;
			cnt_q   <= 5'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (dirty_q) begin
						state_q <= ST_RUN;
						phase_q <= PH_RATIO_XY;
						cnt_q   <= 5'd0;
						dirty_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (cnt_q == LAST_BIT) begin
						cnt_q <= 5'd0;
						if (phase_q == PH_SHIFT)
							state_q <= ST_IDLE;
						else
							phase_q <= phase_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (wr)
				dirty_q <= 1'b1;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE || cnt_q == LAST_BIT) begin
			num_q <= op_num;
			den_q <= op_den;
			rem_q <= 16'd0;
			quo_q <= 32'd0;
		end else begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
		if (state_q == ST_RUN && cnt_q == LAST_BIT) begin
			case (phase_q)
				PH_RATIO_XY: ratio_xy_q <= quo_nx;
				PH_RATIO_Z:  ratio_z_q  <= quo_nx;
				default:     d_q        <= quo_nx[20:0];
			endcase
		end
	end

	assign busy = dirty_q || (state_q != ST_IDLE);

	// derived values
	assign cal.ratio_xy = ratio_xy_q;
	assign cal.ratio_z  = ratio_z_q;
	assign cal.v0 = -{{3{x0_q[19]}}, x0_q};
	assign cal.v1 = -{{3{y0_q[19]}}, y0_q} - {2'b00, d_q};
	assign cal.v2 = -{{3{z0_q[19]}}, z0_q};

endmodule

FILE: src/amfe_sincos.sv
// ----------------------------------------------------------------------------
// amfe_sincos
// Pipelined CORDIC: sine and cosine of three angles, one iteration per stage.
// ----------------------------------------------------------------------------
module amfe_sincos (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            start,
	input  amfe_pkg::ang_t  ang [3],
	input  amfe_pkg::side_t ctx,
	output logic            done,
	output amfe_pkg::sc_t   sine [3],
	output amfe_pkg::sc_t   cosine [3],
	output amfe_pkg::side_t ctx_res
);

	localparam int NIT = 24;

	localparam logic signed [32:0] HALF_PI = 33'sd843314857;
	localparam logic signed [32:0] PI      = 33'sd1686629713;
	localparam logic signed [31:0] CORDIC_K = 32'sd326016437;

	localparam logic signed [32:0] ATAN_TAB [NIT] = '{
		33'sd421657428, 33'sd248918915, 33'sd131521918, 33'sd66762580,
		33'sd33510843,  33'sd16771758,  33'sd8387927,   33'sd4194219,
		33'sd2097141,   33'sd1048575,   33'sd524288,    33'sd262144,
		33'sd131072,    33'sd65536,     33'sd32768,     33'sd16384,
		33'sd8192,      33'sd4096,      33'sd2048,      33'sd1024,
		33'sd512,       33'sd256,       33'sd128,       33'sd64
	};

	logic signed [31:0] x_s  [NIT+1][3];
	logic signed [31:0] y_s  [NIT+1][3];
	logic signed [32:0] th_s [NIT+1][3];
	logic               neg_s [NIT+1][3];
	logic               vld_s [NIT+2];
	amfe_pkg::side_t    side_s [NIT+2];
	amfe_pkg::sc_t      sn_s25 [3];
	amfe_pkg::sc_t      cs_s25 [3];

	logic signed [32:0] th0  [3];
	logic signed [32:0] th_d [3];
	logic               neg_d [3];
	logic signed [31:0] xr [3];
	logic signed [31:0] yr [3];

	// fold the angle into [-pi/2, pi/2]
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			th0[l] = {ang[l][15], ang[l], 16'h0000};
			if (th0[l] > HALF_PI) begin
				th_d[l]  = th0[l] - PI;
				neg_d[l] = 1'b1;
			end else if (th0[l] < -HALF_PI) begin
				th_d[l]  = th0[l] + PI;
				neg_d[l] = 1'b1;
			end else begin
				th_d[l]  = th0[l];
				neg_d[l] = 1'b0;
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NIT + 2; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= start;
			for (int k = 0; k < NIT + 1; k++)
				vld_s[k+1] <= vld_s[k];
		end
	end

	// entry stage and rotation stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= ctx;
			for (int k = 0; k < NIT + 1; k++)
				side_s[k+1] <= side_s[k];
			for (int l = 0; l < 3; l++) begin
				x_s[0][l]   <= CORDIC_K;
				y_s[0][l]   <= 32'sd0;
				th_s[0][l]  <= th_d[l];
				neg_s[0][l] <= neg_d[l];
			end
			for (int g = 0; g < NIT; g++) begin
				for (int l = 0; l < 3; l++) begin
					neg_s[g+1][l] <= neg_s[g][l];
					if (!th_s[g][l][32]) begin
						x_s[g+1][l]  <= x_s[g][l] - (y_s[g][l] >>> g);
						y_s[g+1][l]  <= y_s[g][l] + (x_s[g][l] >>> g);
						th_s[g+1][l] <= th_s[g][l] - ATAN_TAB[g];
					end else begin
						x_s[g+1][l]  <= x_s[g][l] + (y_s[g][l] >>> g);
						y_s[g+1][l]  <= y_s[g][l] - (x_s[g][l] >>> g);
						th_s[g+1][l] <= th_s[g][l] + ATAN_TAB[g];
					end
				end
			end
		end
	end

	// round Q29 to Q16 and undo the fold
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			xr[l] = x_s[NIT][l] + 32'sd4096;
			yr[l] = y_s[NIT][l] + 32'sd4096;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				cs_s25[l] <= neg_s[NIT][l] ? -xr[l][30:13] : xr[l][30:13];
				sn_s25[l] <= neg_s[NIT][l] ? -yr[l][30:13] : yr[l][30:13];
			end
		end
	end

	assign done    = vld_s[NIT+1];
	assign sine    = sn_s25;
	assign cosine  = cs_s25;
	assign ctx_res = side_s[NIT+1];

endmodule

FILE: src/amfe_matrix.sv
// ----------------------------------------------------------------------------
// amfe_matrix
// Rotation product, size ratios, scaling and offset in ten register stages.
// ----------------------------------------------------------------------------
module amfe_matrix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            start,
	input  amfe_pkg::sc_t   sine [3],
	input  amfe_pkg::sc_t   cosine [3],
	input  amfe_pkg::side_t ctx,
	input  amfe_pkg::cal_t  cal,
	output logic            done,
	output amfe_pkg::coef_t coef [3][3],
	output amfe_pkg::coef_t offset [3]
);

	localparam int NST = 10;

	logic            vld_s [NST];
	amfe_pkg::side_t side_s [NST];

	logic signed [35:0] p_s1 [4];
	amfe_pkg::sc_t      sn_s1 [3];
	amfe_pkg::sc_t      cs_s1 [3];
	amfe_pkg::sc_t      a_s2 [3][3];
	amfe_pkg::sc_t      cz_s2, sz_s2;
	logic signed [35:0] pa_s3 [2][3];
	logic signed [35:0] pb_s3 [2][3];
	amfe_pkg::sc_t      a2_s3 [3];
	amfe_pkg::rot_t     r_s4 [3][3];
	logic signed [51:0] q_s5 [3][3];
	logic signed [35:0] e_s6 [3][3];
	logic signed [52:0] f_s7 [3][3];
	amfe_pkg::coef_t    m_s8 [3][3];
	logic signed [54:0] g_s9 [3][3];
	amfe_pkg::coef_t    m_s9 [3][3];
	amfe_pkg::coef_t    m_s10 [3][3];
	amfe_pkg::coef_t    off_s10 [3];

	amfe_pkg::sc_t      a_d [3][3];
	amfe_pkg::rot_t     r_d [3][3];
	logic signed [36:0] rs [2][3];
	logic signed [51:0] et [3][3];
	logic signed [52:0] ft [3][3];
	logic signed [49:0] mr [3][3];
	logic signed [56:0] gs [3];
	logic signed [49:0] os [3];
	amfe_pkg::ratio_t   rat [3];
	amfe_pkg::scl_t     kk [3];
	amfe_pkg::ctr_t     cc [3];
	amfe_pkg::vec_t     vv [3];

	// half-up rounding of a Q32 product to Q16
	function automatic amfe_pkg::sc_t rnd16(input logic signed [35:0] p);
		logic signed [35:0] t;
		t = p + 36'sd32768;
		return t[33:16];
	endfunction

	// clamp to the 32-bit range
	function automatic amfe_pkg::coef_t sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -50'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= start;
			for (int k = 0; k < NST - 1; k++)
				vld_s[k+1] <= vld_s[k];
		end
	end

	// A = Ry * Rx
	always_comb begin
		a_d[0][0] = cs_s1[1];
		a_d[0][1] = rnd16(p_s1[0]);
		a_d[0][2] = rnd16(-p_s1[1]);
		a_d[1][0] = '0;
		a_d[1][1] = cs_s1[0];
		a_d[1][2] = sn_s1[0];
		a_d[2][0] = sn_s1[1];
		a_d[2][1] = rnd16(-p_s1[2]);
		a_d[2][2] = rnd16(p_s1[3]);
	end

	// R = Rz * A, third row passes through
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 2; i++) begin
				rs[i][j] = 37'(pa_s3[i][j]) + 37'(pb_s3[i][j]) + 37'sd32768;
				r_d[i][j] = rs[i][j][34:16];
			end
			r_d[2][j] = 19'(a2_s3[j]);
		end
	end

	// per-row and per-column operands
	always_comb begin
		rat[0] = cal.ratio_xy;
		rat[1] = cal.ratio_xy;
		rat[2] = cal.ratio_z;
		kk[0]  = side_s[5].kx;
		kk[1]  = side_s[5].ky;
		kk[2]  = side_s[5].kz;
		cc[0]  = side_s[8].cx;
		cc[1]  = side_s[8].cy;
		cc[2]  = side_s[8].cz;
		vv[0]  = cal.v0;
		vv[1]  = cal.v1;
		vv[2]  = cal.v2;
	end

	// roundings and offset sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				et[i][j] = q_s5[i][j] + 52'sd32768;
				ft[i][j] = f_s7[i][j] + 53'sd2048;
				mr[i][j] = 50'($signed(ft[i][j][52:12]));
			end
			gs[i] = 57'(g_s9[i][0]) + 57'(g_s9[i][1]) + 57'(g_s9[i][2]) + 57'sd128;
			os[i] = 50'($signed(gs[i][56:8])) + 50'($signed({cc[i], 8'h00}));
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= ctx;
			for (int k = 0; k < NST - 1; k++)
				side_s[k+1] <= side_s[k];
			// stage 1: products of Ry * Rx
			p_s1[0] <= sine[1] * sine[0];
			p_s1[1] <= sine[1] * cosine[0];
			p_s1[2] <= cosine[1] * sine[0];
			p_s1[3] <= cosine[1] * cosine[0];
			sn_s1   <= sine;
			cs_s1   <= cosine;
			// stage 2
			a_s2  <= a_d;
			cz_s2 <= cs_s1[2];
			sz_s2 <= sn_s1[2];
			// stage 3: products of Rz * A
			for (int j = 0; j < 3; j++) begin
				pa_s3[0][j] <= cz_s2 * a_s2[0][j];
				pb_s3[0][j] <= sz_s2 * a_s2[1][j];
				pa_s3[1][j] <= -(sz_s2 * a_s2[0][j]);
				pb_s3[1][j] <= cz_s2 * a_s2[1][j];
				a2_s3[j]    <= a_s2[2][j];
			end
			// stage 4
			r_s4 <= r_d;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					// stage 5: ratio times rotation
					q_s5[i][j] <= $signed({1'b0, rat[i]}) * r_s4[i][j];
					// stage 6
					e_s6[i][j] <= et[i][j][51:16];
					// stage 7: times scale
					f_s7[i][j] <= e_s6[i][j] * $signed({1'b0, kk[j]});
					// stage 8
					m_s8[i][j] <= sat32(mr[i][j]);
					// stage 9: entry times origin shift
					g_s9[i][j] <= m_s8[i][j] * vv[j];
					m_s9[i][j] <= m_s8[i][j];
				end
				// stage 10
				off_s10[i] <= sat32(os[i]);
			end
			m_s10 <= m_s9;
		end
	end

	assign done   = vld_s[NST-1];
	assign coef   = m_s10;
	assign offset = off_s10;

endmodule

FILE: src/affine_map_from_euler_angles.sv
// ----------------------------------------------------------------------------
// affine_map_from_euler_angles
// Builds the 3x4 atlas-to-PET affine map from angles, scales and a centre.
//
// Each item on the pose channel (centre, three angles, three scales) gives
// three rows on the row channel, rows 0, 1, 2, the last flagged by last_row.
// An accepted item passes the 36-stage pipeline and then the row output
// register, which sends its first row; the remaining rows follow one a
// cycle while the receiver is ready. That register sends one row a cycle
// and holds one item at a time; the pipeline ahead of it takes a new item
// in any cycle it can advance and the divider is not busy.
// Configuration sits on an APB port (registers at byte address 4*index).
// After reset and after any register write a serial divider works out the
// size ratios and the anterior shift; while it works, pose.ready is low.
// When the receiver stalls, the row register holds its row and the whole
// pipeline freezes in place once its last stage is full.
// ----------------------------------------------------------------------------
module affine_map_from_euler_angles (
	input  logic                          clk,
	input  logic                          arst_n,
	amfe_in_if.sink                       pose,
	amfe_out_if.source                    row,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [amfe_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	amfe_pkg::cal_t  cal;
	logic            busy;
	logic            adv;
	logic            ld_ok;
	logic            load;
	logic            start;

	amfe_pkg::ang_t  ang [3];
	amfe_pkg::side_t ctx;
	logic            sc_done;
	amfe_pkg::sc_t   sine [3];
	amfe_pkg::sc_t   cosine [3];
	amfe_pkg::side_t sc_ctx;
	logic            mat_done;
	amfe_pkg::coef_t mat_coef [3][3];
	amfe_pkg::coef_t mat_off [3];

	amfe_pkg::coef_t m_q [3][3];
	amfe_pkg::coef_t off_q [3];
	logic [1:0]      cnt_q;
	logic            sv_q;

	assign pready = 1'b1;

	amfe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cal     (cal),
		.busy    (busy)
	);

	// pipeline moves when its last stage is empty or being unloaded
	assign ld_ok      = !sv_q || (row.ready && cnt_q == amfe_pkg::ROW_LAST);
	assign adv        = ld_ok || !mat_done;
	assign load       = mat_done && ld_ok;
	assign pose.ready = adv && !busy;
	assign start      = pose.valid && pose.ready;

	assign ang[0] = pose.angle_x;
	assign ang[1] = pose.angle_y;
	assign ang[2] = pose.angle_z;
	assign ctx.cx = pose.center_x;
	assign ctx.cy = pose.center_y;
	assign ctx.cz = pose.center_z;
	assign ctx.kx = pose.scale_x;
	assign ctx.ky = pose.scale_y;
	assign ctx.kz = pose.scale_z;

	amfe_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.start   (start),
		.ang     (ang),
		.ctx     (ctx),
		.done    (sc_done),
		.sine    (sine),
		.cosine  (cosine),
		.ctx_res (sc_ctx)
	);

	amfe_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.start  (sc_done),
		.sine   (sine),
		.cosine (cosine),
		.ctx    (sc_ctx),
		.cal    (cal),
		.done   (mat_done),
		.coef   (mat_coef),
		.offset (mat_off)
	);

	// row output register: holds one item, sends a row a cycle while the receiver is ready
	always_ff @(posedge clk) begin
		if (load) begin
			m_q   <= mat_coef;
			off_q <= mat_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else if (load) begin
			sv_q  <= 1'b1;
			cnt_q <= 2'd0;
		end else if (sv_q && row.ready) begin
			if (cnt_q == amfe_pkg::ROW_LAST)
				sv_q <= 1'b0;
			else
				cnt_q <= cnt_q + 2'd1;
		end
	end

	assign row.valid       = sv_q;
	assign row.row_index   = cnt_q;
	assign row.coef_first  = m_q[cnt_q][0];
	assign row.coef_second = m_q[cnt_q][1];
	assign row.coef_third  = m_q[cnt_q][2];
	assign row.offset_term = off_q[cnt_q];
	assign row.last_row    = (cnt_q == amfe_pkg::ROW_LAST);

endmodule
